FILE: rtl/irb_pkg.sv
package irb_pkg;

   // Field widths
   localparam int ID_W      = 7;
   localparam int DATA_W    = 32;
   localparam int DEPTH_DEF = 64;

   // stream_length after reset
   localparam logic [ID_W-1:0] LEN_RESET = 7'd64;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   // Request tdata: seq_id, data_word, zero pad
   localparam int REQ_ID_LSB   = 0;
   localparam int REQ_WORD_LSB = REQ_ID_LSB + ID_W;
   localparam int REQ_TDATA_W  = ((ID_W + DATA_W + 7) / 8) * 8;

   // Response tdata: out_word, out_id, zero pad
   localparam int RSP_WORD_LSB = 0;
   localparam int RSP_ID_LSB   = RSP_WORD_LSB + DATA_W;
   localparam int RSP_TDATA_W  = ((ID_W + DATA_W + 7) / 8) * 8;

   // slot index width for a given depth
   function automatic int IDX_W(input int d);
      return (d > 1) ? $clog2(d) : 1;
   endfunction

   // width that holds both an id and a length up to the depth
   function automatic int LEN_W(input int d);
      return (ID_W > $clog2(d + 1)) ? ID_W : $clog2(d + 1);
   endfunction

   typedef enum logic {
      BACK_IDLE,
      BACK_DRAIN
   } back_state_type;

endpackage

FILE: rtl/irb_front.sv
module irb_front
   import irb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [LEN_W(DEPTH)-1:0]       eff_len,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ID_W-1:0]               req_id,
   input  logic [DATA_W-1:0]             req_word,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [IDX_W(DEPTH)+DATA_W-1:0] push_data
);

   localparam int SLOT_W = IDX_W(DEPTH);
   localparam int LW     = LEN_W(DEPTH);

   logic                      valid_ff, valid_in;
   logic [SLOT_W+DATA_W-1:0]  entry_ff;
   logic [LW-1:0]             id_ext;
   logic                      id_ok;
   logic                      take;
   logic [SLOT_W-1:0]         slot;

   // ids of zero or past the stream length are dropped here
   always_comb begin
      id_ext = LW'(req_id);
      id_ok  = (req_id != '0) && (id_ext <= eff_len);
      slot   = SLOT_W'(id_ext - LW'(1));
      take   = req_valid && req_ready;
      if (take) begin
         valid_in = id_ok;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && id_ok) begin
         entry_ff <= {slot, req_word};
      end
   end

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_data  = entry_ff;

endmodule

FILE: rtl/irb_fifo.sv
module irb_fifo
   import irb_pkg::*;
#(
   parameter int WIDTH = DATA_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   always_comb begin
      push      = push_valid && push_ready;
      pop       = pop_valid && pop_ready;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];

endmodule

FILE: rtl/irb_back.sv
module irb_back
   import irb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           restart,
   input  logic [LEN_W(DEPTH)-1:0]        eff_len,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  logic [IDX_W(DEPTH)+DATA_W-1:0] pop_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [DATA_W-1:0]              rsp_word,
   output logic [ID_W-1:0]                rsp_id,
   output logic                           rsp_last
);

   localparam int SLOT_W = IDX_W(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int LW     = LEN_W(DEPTH);

   // slot store, read data registered
   logic [DATA_W-1:0]  mem [DEPTH];
   logic [DATA_W-1:0]  word_q_ff;
   logic [ID_W-1:0]    id_q_ff;
   logic               last_q_ff;

   logic [DEPTH-1:0]   present_ff, present_in;
   logic [CNT_W-1:0]   head_ff, head_in;
   logic               rsp_valid_ff, rsp_valid_in;
   back_state_type     state_ff, state_in;

   logic [SLOT_W-1:0]  pop_slot;
   logic [DATA_W-1:0]  pop_word;
   logic [SLOT_W-1:0]  head_idx, nxt_idx;
   logic [CNT_W-1:0]   nxt_cnt;
   logic               head_in_range, nxt_in_range;
   logic               can_drain, last, out_free, issue, drain_done, pop;

   always_comb begin
      pop_slot      = pop_data[DATA_W +: SLOT_W];
      pop_word      = pop_data[DATA_W-1:0];
      head_idx      = head_ff[SLOT_W-1:0];
      nxt_cnt       = CNT_W'(head_ff + 1'b1);
      nxt_idx       = nxt_cnt[SLOT_W-1:0];
      head_in_range = LW'(head_ff) < eff_len;
      nxt_in_range  = LW'(nxt_cnt) < eff_len;
      can_drain     = (state_ff == BACK_DRAIN) && head_in_range && present_ff[head_idx];
      // run ends unless the following slot is also ready
      last          = !(nxt_in_range && present_ff[nxt_idx]);
      out_free      = !rsp_valid_ff || rsp_ready;
      issue         = can_drain && out_free;
      drain_done    = (state_ff == BACK_DRAIN) && (!can_drain || (issue && last));
      pop           = pop_valid && ((state_ff == BACK_IDLE) || drain_done);

      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (pop) begin
               state_in = BACK_DRAIN;
            end
         end
         BACK_DRAIN: begin
            if (drain_done && !pop) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      present_in = present_ff;
      if (pop) begin
         present_in[pop_slot] = 1'b1;
      end
      head_in = issue ? nxt_cnt : head_ff;

      if (issue) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff     <= BACK_IDLE;
         present_ff   <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // write and read in the same cycle: read returns the old word
   always_ff @(posedge clock) begin
      if (pop) begin
         mem[pop_slot] <= pop_word;
      end
      if (issue) begin
         word_q_ff <= mem[head_idx];
         id_q_ff   <= ID_W'(nxt_cnt);
         last_q_ff <= last;
      end
   end

   assign pop_ready = pop;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = word_q_ff;
   assign rsp_id    = id_q_ff;
   assign rsp_last  = last_q_ff;

endmodule

FILE: rtl/in_order_release_buffer.sv
// In-order release buffer.
// req channel: one request per word, tdata = {pad, data_word, seq_id} with
//   seq_id one-based. Ids of zero or above the stream length are taken and
//   dropped without a response.
// rsp channel: words in sequence order, tdata = {pad, out_id, out_word};
//   tlast marks the final word released by one request.
// csr channel: writes stream_length (clamped to DEPTH) and restarts the
//   stream, clearing all present bits and the head. Write only while idle.
// Path: the first released word of a request passes the front register, the
//   queue, the slot write and the read register before it shows on rsp.
// Throughput: the back end issues one released word per drain step (at least
//   one step per request); the store of the next queued request overlaps the
//   last of those steps, so back-to-back requests that release at most one
//   word go at one per cycle while rsp is not stalled. An idle back end stores first.
// Reset: head and present bits cleared, stream_length = 64.
// Receiver stall: rsp holds its word; the back end waits, and the front
//   keeps taking requests until its register and the two-entry queue fill.
module in_order_release_buffer
   import irb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [6:0] seq_id, [38:7] data_word
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] out_word, [38:32] out_id
   output logic                   rsp_tlast,   // last_of_run
   // config
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ID_W-1:0]        csr_data     // stream_length
);

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int LW     = (ID_W > CNT_W) ? ID_W : CNT_W;
   localparam int ENT_W  = SLOT_W + DATA_W;

   logic [ID_W-1:0]   len_ff;
   logic [LW-1:0]     eff_len;
   logic              restart;

   logic              fq_valid, fq_ready;
   logic [ENT_W-1:0]  fq_data;
   logic              qb_valid, qb_ready;
   logic [ENT_W-1:0]  qb_data;

   logic [DATA_W-1:0] rsp_word;
   logic [ID_W-1:0]   rsp_id;

   // config register; any write restarts the stream
   assign csr_ready = 1'b1;
   assign restart   = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (restart) begin
         len_ff <= csr_data;
      end
   end

   // lengths past the store act as DEPTH
   assign eff_len = (LW'(len_ff) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(len_ff);

   irb_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .eff_len    (eff_len),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_id     (req_tdata[REQ_ID_LSB +: ID_W]),
      .req_word   (req_tdata[REQ_WORD_LSB +: DATA_W]),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data)
   );

   irb_fifo #(.WIDTH(ENT_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   irb_back #(.DEPTH(DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .eff_len   (eff_len),
      .pop_valid (qb_valid),
      .pop_ready (qb_ready),
      .pop_data  (qb_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_word  (rsp_word),
      .rsp_id    (rsp_id),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - ID_W - DATA_W){1'b0}}, rsp_id, rsp_word};

endmodule

FILE: rtl/irb_port_checker.sv
module irb_port_checker
   import irb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   logic [ID_W-1:0] rsp_id;

   assign rsp_id = rsp_tdata[RSP_ID_LSB +: ID_W];

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   a_rsp_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_id != '0)
      else $error("rsp id is zero");

   // inside a run the next id follows on the very next cycle
   a_run_next_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_id == ID_W'($past(rsp_id) + 1'b1)))
      else $error("run broken or id skipped");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind in_order_release_buffer irb_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
